@@ rtl/core/ncdf_pkg.sv @@
// ncdf_pkg: constants, tables and stage word type for the normal cdf pipeline
// no dependencies; used by normal_cdf_approximation
package ncdf_pkg;

    localparam int IN_FRAC_BITS_DEF  = 16;
    localparam int OUT_FRAC_BITS_DEF = 24;

    localparam int ARG_W  = 24;
    localparam int PROB_W = 25;
    localparam int QF     = 30;

    localparam logic [29:0] K_Q32   = 30'd994894385;
    localparam logic [28:0] OOS_Q30 = 29'd428361012;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [30:0] B5_Q30  = 31'd1428371292;
    localparam logic [63:0] BIG_ARG = 64'd9;

    localparam int SERIES_TERMS = 12;
    localparam int RECIP_SH     = 34;

    // horner coefficients b4, b3, b2, b1
    localparam logic signed [33:0] POLY_B [4] = '{
        -34'sd1955558716,
        34'sd1912847369,
        -34'sd382857446,
        34'sd342933307
    };

    // floor(2^34 / n) for the series term divides
    localparam logic [34:0] DIV_MUL [1:12] = '{
        35'd17179869184, 35'd8589934592, 35'd5726623061, 35'd4294967296,
        35'd3435973836,  35'd2863311530, 35'd2454267026, 35'd2147483648,
        35'd1908874353,  35'd1717986918, 35'd1561806289, 35'd1431655765
    };

    typedef struct packed {
        logic                neg;
        logic                zero;
        logic                big;
        logic [23:0]         mag;
        logic [45:0]         d;
        logic [62:0]         rem;
        logic [30:0]         t;
        logic [35:0]         u;
        logic [5:0]          k;
        logic [30:0]         term;
        logic [30:0]         v;
        logic signed [32:0]  sum;
        logic [29:0]         phi;
        logic                psign;
        logic [65:0]         prod;
        logic signed [33:0]  p;
        logic [24:0]         res;
    } ncdf_stage_t;

endpackage

@@ rtl/core/normal_cdf_approximation.sv @@
// normal_cdf_approximation: pipelined standard normal cdf, five-term polynomial form
// depends on ncdf_pkg (constants, coefficient tables, stage word type)
//
//  channel   | valid      | ready      | word
//  ----------+------------+------------+-------------------------------
//  argument  | arg_valid  | arg_ready  | arg_value   (24b signed)
//  result    | prob_valid | prob_ready | probability (25b unsigned)
//
// one word per cycle in and out while results are read; 90 register stages,
// mostly the 31 one-bit stages of the reciprocal divider and the three
// stages per series term
// all stages move together; the whole pipe holds while a result waits unread
// reset clears the valid bits only
module normal_cdf_approximation #(
    parameter int IN_FRAC_BITS  = ncdf_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = ncdf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        arg_valid,
    output logic        arg_ready,
    input  logic [23:0] arg_value,
    output logic        prob_valid,
    input  logic        prob_ready,
    output logic [24:0] probability
);

    localparam int QF      = ncdf_pkg::QF;
    localparam int S_DIV   = 2;
    localparam int S_KD    = S_DIV + 31;
    localparam int S_SER   = S_KD + 6;
    localparam int S_EXP   = S_SER + 3 * ncdf_pkg::SERIES_TERMS;
    localparam int S_POLY  = S_EXP + 2;
    localparam int NST     = S_POLY + 13;

    localparam int U_SH    = 2 * IN_FRAC_BITS + 1 - QF;
    localparam int U_RSH   = (U_SH >= 0) ? U_SH : 0;
    localparam int U_LSH   = (U_SH < 0) ? -U_SH : 0;
    localparam int O_RSH   = (OUT_FRAC_BITS < QF) ? QF - OUT_FRAC_BITS : 0;
    localparam int O_LSH   = (OUT_FRAC_BITS >= QF) ? OUT_FRAC_BITS - QF : 0;
    localparam logic [63:0] O_RND   = (OUT_FRAC_BITS < QF) ?
                                      (64'd1 << (QF - OUT_FRAC_BITS - 1)) : 64'd0;
    localparam logic [63:0] ONE_OUT = 64'd1 << OUT_FRAC_BITS;
    localparam logic [24:0] HALF    = 25'(64'd1 << (OUT_FRAC_BITS - 1));
    localparam logic [63:0] BIG_LIM = ncdf_pkg::BIG_ARG << IN_FRAC_BITS;
    localparam logic [30:0] ONE_Q   = 31'd1 << QF;

    ncdf_pkg::ncdf_stage_t pipe_reg  [NST];
    ncdf_pkg::ncdf_stage_t pipe_next [NST];
    logic [NST-1:0]        valid_reg;
    logic [NST-1:0]        valid_next;
    logic                  adv;

    assign adv        = ~valid_reg[NST-1] | prob_ready;
    assign arg_ready  = adv;
    assign prob_valid = valid_reg[NST-1];
    assign probability = pipe_reg[NST-1].res;
    assign valid_next = {valid_reg[NST-2:0], arg_valid};

    always_comb
    begin
        logic [63:0]        kx;
        logic [63:0]        sq;
        logic [76:0]        dsh;
        logic [36:0]        lsh;
        logic [30:0]        qd;
        logic [35:0]        rm;
        logic [30:0]        ex;
        logic [35:0]        qm;
        logic [30:0]        qc;
        logic [33:0]        pabs;
        logic signed [33:0] sm;
        logic [63:0]        res64;
        int                 ia;

        pipe_next[0]      = '0;
        pipe_next[0].neg  = arg_value[23];
        pipe_next[0].mag  = arg_value[23] ? 24'(-arg_value) : arg_value;
        pipe_next[0].zero = (arg_value == '0);
        pipe_next[0].big  = ({40'd0, pipe_next[0].mag} >= BIG_LIM);
        for (int i = 1; i < NST; i++)
        begin
            pipe_next[i] = pipe_reg[i-1];
        end

        // divisor and argument square
        kx = 64'(ncdf_pkg::K_Q32) * 64'(pipe_reg[0].mag);
        sq = 64'(pipe_reg[0].mag) * 64'(pipe_reg[0].mag);
        pipe_next[1].d    = 46'(64'd1 << 32) + 46'(kx >> IN_FRAC_BITS);
        pipe_next[1].u    = 36'((sq >> U_RSH) << U_LSH);
        pipe_next[1].rem  = 63'(64'd1 << 62);
        pipe_next[1].t    = '0;
        pipe_next[1].k    = '0;
        pipe_next[1].term = ONE_Q;
        pipe_next[1].sum  = 33'(ONE_Q);

        // t = 2^62 / d, one quotient bit per stage
        for (int j = 0; j < 31; j++)
        begin
            ia  = S_DIV + j;
            dsh = 77'(pipe_reg[ia-1].d) << (30 - j);
            if (77'(pipe_reg[ia-1].rem) >= dsh)
            begin
                pipe_next[ia].rem       = pipe_reg[ia-1].rem - dsh[62:0];
                pipe_next[ia].t[30 - j] = 1'b1;
            end
        end

        // u = k*ln2 + r
        for (int j = 0; j < 6; j++)
        begin
            ia  = S_KD + j;
            lsh = 37'(ncdf_pkg::LN2_Q30) << (5 - j);
            if (37'(pipe_reg[ia-1].u) >= lsh)
            begin
                pipe_next[ia].u       = pipe_reg[ia-1].u - lsh[35:0];
                pipe_next[ia].k[5 - j] = 1'b1;
            end
        end

        // exp(-r) series, three stages per term
        for (int n = 1; n <= ncdf_pkg::SERIES_TERMS; n++)
        begin
            ia = S_SER + 3 * (n - 1);
            pipe_next[ia].prod = 66'(pipe_reg[ia-1].term) * 66'(pipe_reg[ia-1].u[29:0]);

            pipe_next[ia+1].v    = 31'(pipe_reg[ia].prod >> QF);
            pipe_next[ia+1].prod = 66'(pipe_next[ia+1].v) * 66'(ncdf_pkg::DIV_MUL[n]);

            qd = 31'(pipe_reg[ia+1].prod >> ncdf_pkg::RECIP_SH);
            rm = 36'(pipe_reg[ia+1].v) - 36'(qd) * 36'(n);
            if (rm >= 36'(n))
            begin
                qd = qd + 31'd1;
            end
            pipe_next[ia+2].term = qd;
            if (n[0])
            begin
                pipe_next[ia+2].sum = pipe_reg[ia+1].sum - $signed({2'b00, qd});
            end
            else
            begin
                pipe_next[ia+2].sum = pipe_reg[ia+1].sum + $signed({2'b00, qd});
            end
        end

        // scale by 2^-k, then by 1/sqrt(2 pi)
        ex = pipe_reg[S_EXP-1].sum[32] ? 31'd0 : pipe_reg[S_EXP-1].sum[30:0];
        pipe_next[S_EXP].term   = ex >> pipe_reg[S_EXP-1].k;
        pipe_next[S_EXP+1].prod = 66'(pipe_reg[S_EXP].term) * 66'(ncdf_pkg::OOS_Q30);

        pipe_next[S_POLY].phi   = pipe_reg[S_POLY-1].big ? 30'd0 :
                                  30'(pipe_reg[S_POLY-1].prod >> QF);
        pipe_next[S_POLY].prod  = 66'(ncdf_pkg::B5_Q30) * 66'(pipe_reg[S_POLY-1].t);
        pipe_next[S_POLY].psign = 1'b0;

        // horner steps
        for (int m = 0; m < 4; m++)
        begin
            ia = S_POLY + 1 + 2 * m;
            sm = $signed({1'b0, pipe_reg[ia-1].prod[QF+32:QF]});
            pipe_next[ia].p = ncdf_pkg::POLY_B[m] + (pipe_reg[ia-1].psign ? -sm : sm);

            pabs = pipe_reg[ia].p[33] ? 34'(-pipe_reg[ia].p) : 34'(pipe_reg[ia].p);
            pipe_next[ia+1].psign = pipe_reg[ia].p[33];
            pipe_next[ia+1].prod  = 66'(pabs) * 66'(pipe_reg[ia].t);
        end

        ia = S_POLY + 9;
        sm = $signed({1'b0, pipe_reg[ia-1].prod[QF+32:QF]});
        pipe_next[ia].p = pipe_reg[ia-1].psign ? -sm : sm;

        pabs = pipe_reg[ia].p[33] ? 34'(-pipe_reg[ia].p) : 34'(pipe_reg[ia].p);
        pipe_next[ia+1].psign = pipe_reg[ia].p[33];
        pipe_next[ia+1].prod  = 66'(pabs) * 66'(pipe_reg[ia].phi);

        // clamp q, fold by sign of x
        qm = pipe_reg[ia+1].prod[QF+35:QF];
        if (pipe_reg[ia+1].psign)
        begin
            qc = 31'd0;
        end
        else if (qm > 36'(ONE_Q))
        begin
            qc = ONE_Q;
        end
        else
        begin
            qc = qm[30:0];
        end
        pipe_next[ia+2].p = pipe_reg[ia+1].neg ? 34'(qc) : 34'(ONE_Q - qc);

        // output rounding and saturation
        res64 = ((64'(pipe_reg[ia+2].p[30:0]) + O_RND) >> O_RSH) << O_LSH;
        if (res64 > ONE_OUT)
        begin
            res64 = ONE_OUT;
        end
        pipe_next[ia+3].res = pipe_reg[ia+2].zero ? HALF : res64[24:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NST; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipe moved while stalled");

    a_recip_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_KD-1] && !pipe_reg[S_KD-1].zero |-> !pipe_reg[S_KD-1].t[30])
        else $error("reciprocal not below one");

    a_resid_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[S_SER-1] && !pipe_reg[S_SER-1].big |->
        pipe_reg[S_SER-1].u < 36'(ncdf_pkg::LN2_Q30))
        else $error("exp residue out of range");

    a_prob_max: assert property (@(posedge clk) disable iff (!rst_n)
        prob_valid && (OUT_FRAC_BITS <= 24) |-> {39'd0, probability} <= ONE_OUT)
        else $error("probability above one");

endmodule
